>>> rtl/lfg_pkg.sv
// Shared widths, curve tables, reciprocals and interface types of the LiPo fuel gauge.
`timescale 1ns / 1ps

package lfg_pkg;

	localparam int SAMPLES_PER_READING = 30;

	localparam int SAMPLE_W  = 12;
	localparam int SUM_W     = 18;
	localparam int GAIN_W    = 16;
	localparam int GAIN_FRAC = 14;
	localparam int MV_W      = 15;
	localparam int PCT_W     = 7;
	localparam int CNT_W     = $clog2(SAMPLES_PER_READING + 1);
	localparam int PROD_W    = SUM_W + GAIN_W;
	// Product times two, shifted right by the gain fraction.
	localparam int SCL_W     = PROD_W - GAIN_FRAC + 1;
	localparam int CMV_W     = 13;
	localparam int OFF_W     = 9;
	localparam int SEG_W     = 3;

	// Division by the window length is a multiplication by the rounded-up reciprocal.
	// With a numerator below 2^SCL_W and a window of at most 64 samples the error of
	// the reciprocal stays below one step, so the truncated quotient is exact.
	localparam int AVG_SHIFT = 27;
	// Percent step: offset times the rounded-up rise over span, scaled by 2^16.
	localparam int PCT_SHIFT = 16;
	localparam int PREC_W    = 15;

	localparam int MUL_A_W   = SCL_W;
	localparam int MUL_B_W   = AVG_SHIFT + 1;
	localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
	localparam int MQ_W      = SCL_W;

	localparam logic [GAIN_W-1:0]  GAIN_RESET = GAIN_W'(16384);
	localparam logic [MV_W-1:0]    MV_MAX     = {MV_W{1'b1}};
	localparam logic [MUL_B_W-1:0] AVG_RECIP  = MUL_B_W'(((1 << AVG_SHIFT) +
		SAMPLES_PER_READING - 1) / SAMPLES_PER_READING);

	typedef enum logic [1:0] {
		OP_SCALE = 2'd0,
		OP_AVG   = 2'd1,
		OP_PCT   = 2'd2
	} mul_op_t;

	typedef struct packed {
		mul_op_t            op;
		logic [MUL_A_W-1:0] a;
		logic [MUL_B_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic             last;
		logic [SUM_W-1:0] sum;
	} acc_t;

	function automatic logic [CMV_W-1:0] curve_mv(input logic [SEG_W-1:0] k);
		logic [CMV_W-1:0] v;
		unique case (k)
			3'd0:    v = CMV_W'(3300);
			3'd1:    v = CMV_W'(3600);
			3'd2:    v = CMV_W'(3700);
			3'd3:    v = CMV_W'(3750);
			3'd4:    v = CMV_W'(3850);
			3'd5:    v = CMV_W'(3950);
			3'd6:    v = CMV_W'(4050);
			default: v = CMV_W'(4200);
		endcase
		return v;
	endfunction

	function automatic logic [PCT_W-1:0] curve_pct(input logic [SEG_W-1:0] k);
		logic [PCT_W-1:0] v;
		unique case (k)
			3'd0:    v = PCT_W'(0);
			3'd1:    v = PCT_W'(10);
			3'd2:    v = PCT_W'(25);
			3'd3:    v = PCT_W'(40);
			3'd4:    v = PCT_W'(60);
			3'd5:    v = PCT_W'(75);
			3'd6:    v = PCT_W'(90);
			default: v = PCT_W'(100);
		endcase
		return v;
	endfunction

	// Rise over span of each segment, rounded up. Offsets stay below 300 mV, so the
	// shifted product truncates to the same percent as the exact interpolation.
	function automatic logic [PREC_W-1:0] seg_recip(input logic [SEG_W-1:0] k);
		logic [PREC_W-1:0] v;
		unique case (k)
			3'd0:    v = PREC_W'(((10 << PCT_SHIFT) + 299) / 300);
			3'd1:    v = PREC_W'(((15 << PCT_SHIFT) + 99) / 100);
			3'd2:    v = PREC_W'(((15 << PCT_SHIFT) + 49) / 50);
			3'd3:    v = PREC_W'(((20 << PCT_SHIFT) + 99) / 100);
			3'd4:    v = PREC_W'(((15 << PCT_SHIFT) + 99) / 100);
			3'd5:    v = PREC_W'(((15 << PCT_SHIFT) + 99) / 100);
			3'd6:    v = PREC_W'(((10 << PCT_SHIFT) + 149) / 150);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

>>> rtl/lfg_accum.sv
// Window accumulator: sums samples and flags the last sample of each window.
`timescale 1ns / 1ps

module lfg_accum (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  logic [lfg_pkg::SAMPLE_W-1:0]  sample,
	output lfg_pkg::acc_t                 win
);
	import lfg_pkg::*;

	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_next;

	assign cnt_next = cnt_q + CNT_W'(1);
	assign win.sum  = sum_q + SUM_W'(sample);
	assign win.last = fire && (cnt_next == CNT_W'(SAMPLES_PER_READING));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (fire) begin
			if (win.last) begin
				sum_q <= '0;
				cnt_q <= '0;
			end else begin
				sum_q <= win.sum;
				cnt_q <= cnt_next;
			end
		end
	end

endmodule

>>> rtl/lfg_divider.sv
// Shared reciprocal divider: one multiplier followed by a fixed shift per operation.
`timescale 1ns / 1ps

module lfg_divider (
	input  lfg_pkg::mul_req_t           req,
	output logic [lfg_pkg::MQ_W-1:0]    quotient
);
	import lfg_pkg::*;

	logic [MUL_P_W-1:0] prod;

	always_comb begin
		prod = MUL_P_W'(req.a) * MUL_P_W'(req.b);
		unique case (req.op)
			OP_SCALE: quotient = MQ_W'(prod >> (GAIN_FRAC - 1));
			OP_AVG:   quotient = MQ_W'(prod >> AVG_SHIFT);
			OP_PCT:   quotient = MQ_W'(prod >> PCT_SHIFT);
			default:  quotient = '0;
		endcase
	end

endmodule

>>> rtl/lipo_fuel_gauge_top.sv
// Top level of the LiPo fuel gauge: sequencer, shared reciprocal divider and output register.
`timescale 1ns / 1ps
// Samples that do not close a window are taken back to back.
// The closing sample starts a reading that uses the shared multiplier for the gain
// product, the division by the window length and, inside the curve, the percent step.
// out_valid rises once the reading has passed SCALE, AVG, SEG, PCT (skipped outside
// the curve) and OUT, later only while the previous reading waits; in_ready is low
// until then. Reset clears the window, sequencer and out_valid; gain 1.0.

module lipo_fuel_gauge_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [lfg_pkg::GAIN_W-1:0]   cfg_wr_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [lfg_pkg::SAMPLE_W-1:0] sample_mv,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [lfg_pkg::MV_W-1:0]     battery_mv,
	output logic [lfg_pkg::PCT_W-1:0]    charge_percent
);
	import lfg_pkg::*;

	// Sequencer states, one-hot. The reading walks SCALE, AVG, SEG and, when the
	// voltage falls inside the curve, PCT, before OUT hands it over.
	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_SCALE = 6'b000010,
		S_AVG   = 6'b000100,
		S_SEG   = 6'b001000,
		S_PCT   = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	state_t            state_q;
	logic [GAIN_W-1:0] gain_q;
	logic [SUM_W-1:0]  sum_q;
	logic [SCL_W-1:0]  scl_q;
	logic [MV_W-1:0]   mv_q;
	logic [OFF_W-1:0]  off_q;
	logic [SEG_W-1:0]  seg_q;
	logic [PCT_W-1:0]  pct_q;
	logic              out_valid_q;
	logic [MV_W-1:0]   out_mv_q;
	logic [PCT_W-1:0]  out_pct_q;

	logic              in_fire;
	logic              out_load;
	acc_t              win;
	mul_req_t          mul_req;
	logic [MQ_W-1:0]   mul_q;

	logic              mv_low;
	logic              mv_high;
	logic [SEG_W-1:0]  seg_idx;
	logic [CMV_W-1:0]  seg_base;
	logic [MV_W-1:0]   seg_off;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;

	// The calibration register takes every write; the open window is left alone.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
		end else if (cfg_wr_en) begin
			gain_q <= cfg_wr_data;
		end
	end

	lfg_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (in_fire),
		.sample (sample_mv),
		.win    (win)
	);

	// One multiplier serves all three steps, with operands from registers. The gain
	// step keeps the product times two shifted down by the gain fraction; the floor
	// of a floor stays exact when it is then divided by the window length.
	always_comb begin
		if (state_q == S_AVG) begin
			mul_req.op = OP_AVG;
			mul_req.a  = scl_q;
			mul_req.b  = AVG_RECIP;
		end else if (state_q == S_PCT) begin
			mul_req.op = OP_PCT;
			mul_req.a  = MUL_A_W'(off_q);
			mul_req.b  = MUL_B_W'(seg_recip(seg_q));
		end else begin
			mul_req.op = OP_SCALE;
			mul_req.a  = MUL_A_W'(sum_q);
			mul_req.b  = MUL_B_W'(gain_q);
		end
	end

	lfg_divider u_divider (
		.req      (mul_req),
		.quotient (mul_q)
	);

	// Segment pick: a voltage equal to an inner curve point takes the segment
	// that starts there, so it reads that point's percent exactly.
	always_comb begin
		mv_low  = (mv_q <= MV_W'(curve_mv(SEG_W'(0))));
		mv_high = (mv_q >= MV_W'(curve_mv(SEG_W'(7))));
		seg_idx = '0;
		for (int k = 1; k < 7; k++) begin
			if (mv_q >= MV_W'(curve_mv(SEG_W'(k)))) begin
				seg_idx = SEG_W'(k);
			end
		end
		seg_base = curve_mv(seg_idx);
		seg_off  = mv_q - MV_W'(seg_base);
	end

	// A finished reading waits in OUT only while the output register still holds
	// the previous one that has not been transferred.
	assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (win.last) begin
						state_q <= S_SCALE;
					end
				end
				S_SCALE: begin
					state_q <= S_AVG;
				end
				S_AVG: begin
					state_q <= S_SEG;
				end
				S_SEG: begin
					if (mv_low || mv_high) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_PCT;
					end
				end
				S_PCT: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Working registers of the reading.
	always_ff @(posedge clk) begin
		if (win.last) begin
			sum_q <= win.sum;
		end
		if (state_q == S_SCALE) begin
			scl_q <= mul_q;
		end
		if (state_q == S_AVG) begin
			// Saturate the averaged voltage at the top of its field.
			if (mul_q > MQ_W'(MV_MAX)) begin
				mv_q <= MV_MAX;
			end else begin
				mv_q <= mul_q[MV_W-1:0];
			end
		end
		if (state_q == S_SEG) begin
			seg_q <= seg_idx;
			off_q <= seg_off[OFF_W-1:0];
			if (mv_low) begin
				pct_q <= curve_pct(SEG_W'(0));
			end else begin
				pct_q <= curve_pct(SEG_W'(7));
			end
		end
		if (state_q == S_PCT) begin
			pct_q <= curve_pct(seg_q) + mul_q[PCT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_mv_q  <= mv_q;
			out_pct_q <= pct_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign battery_mv     = out_mv_q;
	assign charge_percent = out_pct_q;

	// A reading that waits for the receiver stays put until it is transferred.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(out_mv_q) && $stable(out_pct_q))
		else $error("waiting reading dropped or changed");

	// The charge stays within range and agrees with the curve ends.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_pct_q <= PCT_W'(100))
			&& ((out_mv_q > MV_W'(3300)) || (out_pct_q == PCT_W'(0)))
			&& ((out_mv_q < MV_W'(4200)) || (out_pct_q == PCT_W'(100))))
		else $error("charge out of range or off the curve ends");

	// No sample is taken while a reading is in progress.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !in_ready)
		else $error("sample accepted during a reading");

endmodule
